FILE: design/dmoc_pkg.sv
// ----------------------------------------------------------------------------
// dmoc_pkg
// Shared types and constants of the budgeted direct-mapped object cache.
// ----------------------------------------------------------------------------
package dmoc_pkg;

  localparam int OFF_W       = 64;
  localparam int KIND_W      = 3;
  localparam int SIZE_W      = 32;
  localparam int HND_W       = 32;
  localparam int BUD_W       = 42;
  localparam int CFG_IDX_W   = 8;
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 112;

  localparam logic [CFG_IDX_W-1:0] CFG_MEM_LIMIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODE  = 8'd1;
  localparam logic [BUD_W-1:0]     LIMIT_RST     = 42'd67108864;
  localparam logic [KIND_W-1:0]    BLOB_KIND     = 3'd3;

  typedef struct packed {
    logic [OFF_W-1:0]  key;
    logic [SIZE_W-1:0] bytes;
    logic [KIND_W-1:0] kind;
    logic [HND_W-1:0]  hnd;
  } rec_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_HADD, CMD_MOD, CMD_RD_S, CMD_CAP_S, CMD_DEC,
    CMD_WR1, CMD_WR2, CMD_EV_START, CMD_P_RD, CMD_P_GO, CMD_E_RD, CMD_E_CHK,
    CMD_E_END, CMD_RES_LU, CMD_RES_OK, CMD_RES_NO
  } dp_cmd_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_HADD, ST_MOD, ST_RD_S, ST_CAP_S, ST_DEC, ST_WR1, ST_WR2,
    ST_EV_START, ST_P_RD, ST_P_GO, ST_E_TEST, ST_E_RD, ST_E_CHK,
    ST_RES_LU, ST_RES_OK, ST_RES_NO
  } ctrl_state_t;

  typedef struct packed {
    logic clr_last;
    logic hadd_last;
    logic mod_last;
    logic is_store;
    logic oversize;
    logic need_evict;
    logic refuse2;
    logic need_w2;
    logic e_cont;
    logic blobs;
    logic out_free;
  } dp_status_t;

endpackage

FILE: design/dmoc_ctrl.sv
// ----------------------------------------------------------------------------
// dmoc_ctrl
// Sequencer of the cache: steps each transaction through hashing, slot
// access, eviction and result delivery.
// ----------------------------------------------------------------------------
module dmoc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  dmoc_pkg::dp_status_t st,
  output logic                 in_ready,
  output dmoc_pkg::dp_cmd_t    cmd
);
  import dmoc_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (st.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_HADD;
      ST_HADD:     if (st.hadd_last) state_nxt = ST_MOD;
      ST_MOD:      if (st.mod_last) state_nxt = ST_RD_S;
      ST_RD_S:     state_nxt = ST_CAP_S;
      ST_CAP_S:    state_nxt = ST_DEC;
      ST_DEC: begin
        if (!st.is_store) state_nxt = ST_RES_LU;
        else if (st.oversize || st.refuse2) state_nxt = ST_RES_NO;
        else if (st.need_evict) state_nxt = ST_EV_START;
        else state_nxt = ST_WR1;
      end
      ST_WR1:      state_nxt = st.need_w2 ? ST_WR2 : ST_RES_OK;
      ST_WR2:      state_nxt = ST_RES_OK;
      ST_EV_START: state_nxt = ST_P_RD;
      ST_P_RD:     state_nxt = ST_P_GO;
      ST_P_GO:     state_nxt = ST_E_TEST;
      ST_E_TEST: begin
        if (st.e_cont) state_nxt = ST_E_RD;
        else if (st.blobs) state_nxt = ST_P_RD;
        else state_nxt = ST_RD_S;
      end
      ST_E_RD:     state_nxt = ST_E_CHK;
      ST_E_CHK:    state_nxt = ST_E_TEST;
      ST_RES_LU, ST_RES_OK, ST_RES_NO: if (st.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = CMD_NONE;
    case (state_r)
      ST_CLEAR:    cmd = CMD_CLEAR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = CMD_LOAD;
      end
      ST_HADD:     cmd = CMD_HADD;
      ST_MOD:      cmd = CMD_MOD;
      ST_RD_S:     cmd = CMD_RD_S;
      ST_CAP_S:    cmd = CMD_CAP_S;
      ST_DEC:      cmd = CMD_DEC;
      ST_WR1:      cmd = CMD_WR1;
      ST_WR2:      cmd = CMD_WR2;
      ST_EV_START: cmd = CMD_EV_START;
      ST_P_RD:     cmd = CMD_P_RD;
      ST_P_GO:     cmd = CMD_P_GO;
      ST_E_TEST:   if (!st.e_cont) cmd = CMD_E_END;
      ST_E_RD:     cmd = CMD_E_RD;
      ST_E_CHK:    cmd = CMD_E_CHK;
      ST_RES_LU:   if (st.out_free) cmd = CMD_RES_LU;
      ST_RES_OK:   if (st.out_free) cmd = CMD_RES_OK;
      ST_RES_NO:   if (st.out_free) cmd = CMD_RES_NO;
      default:     cmd = CMD_NONE;
    endcase
  end

endmodule

FILE: design/dmoc_dp.sv
// ----------------------------------------------------------------------------
// dmoc_dp
// Datapath of the cache: slot memories, hash unit, budget accounting,
// list walker, configuration registers and the result register.
// ----------------------------------------------------------------------------
module dmoc_dp #(
  parameter int ENTRIES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dmoc_pkg::dp_cmd_t                    cmd,
  output dmoc_pkg::dp_status_t                 st,
  input  logic [dmoc_pkg::IN_TDATA_W-1:0]      in_data,
  input  logic                                 in_op,
  input  logic                                 cfg_we,
  input  logic [dmoc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [dmoc_pkg::BUD_W-1:0]           cfg_wdata,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [dmoc_pkg::OUT_TDATA_W-1:0]     out_data
);
  import dmoc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int FW = SIZE_W + AW + 1;
  localparam int CW = 64;
  localparam logic [AW-1:0] TAIL  = AW'(ENTRIES - 1);
  localparam logic [31:0]   MODV  = 32'(ENTRIES - 1);
  localparam logic [31:0]   RECIP = 32'((64'd1 << 32) / 64'(ENTRIES - 1));

  function automatic logic [AW-1:0] bound(input logic [AW-1:0] x);
    bound = ({1'b0, x} < (AW + 1)'(ENTRIES)) ? x : TAIL;
  endfunction

  rec_t          rec_mem [ENTRIES];
  logic [AW-1:0] aft_mem [ENTRIES];
  logic [AW-1:0] bef_mem [ENTRIES];
  rec_t          rec_rd_r;
  logic [AW-1:0] aft_rd_r, bef_rd_r;

  logic [AW-1:0] rd_addr;
  logic          rec_we, aft_we, bef_we;
  logic [AW-1:0] rec_wa, aft_wa, bef_wa;
  rec_t          rec_wd;
  logic [AW-1:0] aft_wd, bef_wd;

  logic [AW-1:0]     clr_idx_r;
  logic [5:0]        cnt_r;
  logic              op_r;
  logic [OFF_W-1:0]  off_r, h_r;
  logic [KIND_W-1:0] kind_r;
  logic [SIZE_W-1:0] size_r;
  logic [HND_W-1:0]  hnd_r;
  logic [AW-1:0]     rem_r, s_r, p_r, e_r;
  logic [63:0]       prod_r;
  rec_t              orec_r;
  logic [AW-1:0]     s_aft_r, s_bef_r;
  logic [BUD_W-1:0]  biu_r, limit_r, target_r;
  logic              seq_r, blobs_r, evicted_r;
  logic [FW-1:0]     freed_r;
  logic [AW:0]       steps_r;
  logic              out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [OFF_W-1:0]  hterm;
  logic [15:0]       digit;
  logic [31:0]       mod_in, mod_qm, mod_raw, mod_v;
  logic [AW-1:0]     mod_s;
  logic [SIZE_W-1:0] growth;
  logic [BUD_W-1:0]  half;
  logic              ev_hit, lu_hit;
  logic [AW-1:0]     ev_a, ev_b, sa, sb;

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    hterm = off_r >> 8;
      2'd1:    hterm = off_r >> 16;
      2'd2:    hterm = off_r >> 24;
      default: hterm = off_r >> 32;
    endcase
    case (cnt_r[2:1])
      2'd0:    digit = h_r[63:48];
      2'd1:    digit = h_r[47:32];
      2'd2:    digit = h_r[31:16];
      default: digit = h_r[15:0];
    endcase
    mod_in  = (32'(rem_r) << 16) | {16'd0, digit};
    mod_qm  = prod_r[63:32] * MODV;
    mod_raw = mod_in - mod_qm;
    mod_v   = (mod_raw >= MODV) ? mod_raw - MODV : mod_raw;
    mod_s   = (mod_v == '0) ? AW'(1) : mod_v[AW-1:0];
    growth  = (size_r > orec_r.bytes) ? size_r - orec_r.bytes : '0;
    half    = biu_r >> 1;
    ev_hit  = !blobs_r || (rec_rd_r.kind == BLOB_KIND);
    ev_a    = bound(aft_rd_r);
    ev_b    = bound(bef_rd_r);
    sa      = bound(s_aft_r);
    sb      = bound(s_bef_r);
    lu_hit  = (orec_r.key == off_r) && (orec_r.bytes != '0);
  end

  always_comb begin
    st.clr_last   = (clr_idx_r == TAIL);
    st.hadd_last  = (cnt_r[1:0] == 2'd3);
    st.mod_last   = (cnt_r == 6'd7);
    st.is_store   = op_r;
    st.oversize   = ({10'd0, size_r, 1'b0} > {1'b0, limit_r});
    st.need_evict = !evicted_r &&
                    (({1'b0, biu_r} + (BUD_W + 1)'(growth)) > {1'b0, limit_r});
    st.refuse2    = evicted_r &&
                    (({1'b0, biu_r} + (BUD_W + 1)'(size_r)) > {1'b0, limit_r});
    st.need_w2    = (orec_r.bytes == '0) && (size_r != '0);
    st.e_cont     = (CW'(freed_r) < CW'(target_r)) && (e_r != TAIL) && (e_r != '0) &&
                    (steps_r < (AW + 1)'(ENTRIES));
    st.blobs      = blobs_r;
    st.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    rd_addr = s_r;
    rec_we = 1'b0; aft_we = 1'b0; bef_we = 1'b0;
    rec_wa = s_r;  aft_wa = s_r;  bef_wa = s_r;
    rec_wd = '0;   aft_wd = '0;   bef_wd = '0;
    case (cmd)
      CMD_CLEAR: begin
        rec_we = 1'b1; aft_we = 1'b1; bef_we = 1'b1;
        rec_wa = clr_idx_r; aft_wa = clr_idx_r; bef_wa = clr_idx_r;
        aft_wd = (clr_idx_r == '0) ? TAIL : '0;
      end
      CMD_CAP_S: rd_addr = TAIL;
      CMD_P_RD:  rd_addr = '0;
      CMD_E_RD:  rd_addr = e_r;
      CMD_WR1: begin
        rec_we = 1'b1;
        rec_wd = '{key: off_r, bytes: size_r, kind: kind_r, hnd: hnd_r};
        if (orec_r.bytes != '0 && size_r == '0) begin
          bef_we = 1'b1; bef_wa = sa; bef_wd = sb;
          aft_we = 1'b1; aft_wa = sb; aft_wd = sa;
        end else if (orec_r.bytes == '0 && size_r != '0) begin
          aft_we = 1'b1; aft_wa = s_r; aft_wd = TAIL;
          bef_we = 1'b1; bef_wa = s_r; bef_wd = p_r;
        end
      end
      CMD_WR2: begin
        aft_we = 1'b1; aft_wa = p_r;  aft_wd = s_r;
        bef_we = 1'b1; bef_wa = TAIL; bef_wd = s_r;
      end
      CMD_E_CHK: begin
        if (ev_hit) begin
          rec_we = 1'b1; rec_wa = e_r;
          if (rec_rd_r.bytes != '0) begin
            bef_we = 1'b1; bef_wa = ev_a; bef_wd = ev_b;
            aft_we = 1'b1; aft_wa = ev_b; aft_wd = ev_a;
          end
        end
      end
      default: rd_addr = s_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    if (aft_we) aft_mem[aft_wa] <= aft_wd;
    if (bef_we) bef_mem[bef_wa] <= bef_wd;
    rec_rd_r <= rec_mem[rd_addr];
    aft_rd_r <= aft_mem[rd_addr];
    bef_rd_r <= bef_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      biu_r       <= '0;
      limit_r     <= LIMIT_RST;
      seq_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CFG_MEM_LIMIT) limit_r <= cfg_wdata;
      if (cfg_we && cfg_idx == CFG_SEQ_MODE) seq_r <= cfg_wdata[0];
      if (cmd == CMD_RES_LU || cmd == CMD_RES_OK || cmd == CMD_RES_NO) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_CLEAR: clr_idx_r <= clr_idx_r + AW'(1);
        CMD_WR1:   biu_r <= biu_r - BUD_W'(orec_r.bytes) + BUD_W'(size_r);
        CMD_E_CHK: if (ev_hit) biu_r <= biu_r - BUD_W'(rec_rd_r.bytes);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op_r      <= in_op;
        off_r     <= in_data[63:0];
        kind_r    <= in_data[66:64];
        size_r    <= in_data[98:67];
        hnd_r     <= in_data[130:99];
        h_r       <= in_data[63:0];
        cnt_r     <= '0;
        rem_r     <= '0;
        freed_r   <= '0;
        evicted_r <= 1'b0;
        blobs_r   <= 1'b0;
      end
      CMD_HADD: begin
        h_r   <= h_r + hterm;
        cnt_r <= (cnt_r[1:0] == 2'd3) ? 6'd0 : cnt_r + 6'd1;
      end
      CMD_MOD: begin
        if (!cnt_r[0]) prod_r <= 64'(mod_in) * 64'(RECIP);
        else rem_r <= mod_v[AW-1:0];
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd7) s_r <= mod_s;
      end
      CMD_CAP_S: begin
        orec_r  <= rec_rd_r;
        s_aft_r <= aft_rd_r;
        s_bef_r <= bef_rd_r;
      end
      CMD_DEC: p_r <= bound(bef_rd_r);
      CMD_EV_START: begin
        blobs_r  <= seq_r;
        target_r <= (!seq_r && half > BUD_W'(size_r)) ? half : BUD_W'(size_r);
      end
      CMD_P_GO: begin
        e_r     <= bound(aft_rd_r);
        steps_r <= '0;
      end
      CMD_E_CHK: begin
        if (ev_hit) freed_r <= freed_r + FW'(rec_rd_r.bytes);
        e_r     <= ev_a;
        steps_r <= steps_r + (AW + 1)'(1);
      end
      CMD_E_END: begin
        evicted_r <= evicted_r || !blobs_r;
        blobs_r   <= 1'b0;
      end
      CMD_RES_LU: out_data_r <= {1'b0, BUD_W'(0), lu_hit ? orec_r.hnd : HND_W'(0),
                                 lu_hit ? orec_r.bytes : SIZE_W'(0),
                                 lu_hit ? orec_r.kind : KIND_W'(0), 1'b0, lu_hit};
      CMD_RES_OK: out_data_r <= {1'b0, BUD_W'(freed_r), (OUT_TDATA_W - BUD_W - 3)'(0),
                                 1'b1, 1'b0};
      CMD_RES_NO: out_data_r <= {1'b0, BUD_W'(freed_r), (OUT_TDATA_W - BUD_W - 3)'(0),
                                 1'b0, 1'b0};
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/budgeted_direct_mapped_object_cache.sv
// ----------------------------------------------------------------------------
// budgeted_direct_mapped_object_cache
// Direct-mapped cache of object records with a byte budget and eviction in
// insertion order.
//
//   Channel  Direction  Handshake              Payload
//   in_      slave      in_tvalid/in_tready    tuser: opcode; tdata: record
//   out_     master     out_tvalid/out_tready  tdata: result
//   cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// After acceptance the hash of the offset is summed and then reduced modulo
// ENTRIES-1 one 16-bit digit at a time by reciprocal multiplication; then the
// slot is read. A store may first evict, walking the insertion list in
// passes and checking one visited slot at a time.
// After reset a clearing pass writes every slot before in_tready rises.
// One transaction is in work at a time; a finished result waits in the
// output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module budgeted_direct_mapped_object_cache #(
  parameter int ENTRIES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // offset[63:0], obj_type[66:64], obj_size[98:67], data_handle[130:99], zeros
  input  logic [dmoc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit[0], accepted[1], type_out[4:2], size_out[36:5], handle_out[68:37],
  // bytes_freed[110:69], zero
  output logic [dmoc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dmoc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmoc_pkg::BUD_W-1:0]         cfg_data
);
  import dmoc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ready = 1'b1;

  dmoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .st       (st),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  dmoc_dp #(.ENTRIES(ENTRIES)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_tdata),
    .in_op     (in_tuser),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
